[rtl/fmsd_pkg.sv]
`default_nettype none
package fmsd_pkg;

  localparam int QueueDepth = 128;
  localparam int MaxServers = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int SrvW       = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int ActW       = 3;
  localparam int LenW       = 8;
  localparam int IdW        = 16;
  localparam int TickW      = 32;
  localparam int ServedW    = 32;
  localparam int SumW       = 48;
  localparam int LevelW     = 7;
  localparam int IdxW       = 2;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 184;

  localparam logic [ActW-1:0] ActiveReset = ActW'(2);

  typedef enum logic [1:0] {
    IdleSt,
    FetchSt,
    ServeSt
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] arrived;
    logic [LenW-1:0]  length;
  } job_t;

  localparam int JobW = $bits(job_t);

  typedef struct packed {
    logic [4:0]         pad;
    logic               arrival_dropped;
    logic [LevelW-1:0]  waiting_count;
    logic [SumW-1:0]    wait_total;
    logic [ServedW-1:0] served_total;
    logic [TickW-1:0]   tick_now;
    logic [LenW-1:0]    busy_left;
    logic [TickW-1:0]   wait_ticks;
    logic [IdW-1:0]     job_id;
    logic               started;
    logic [IdxW-1:0]    server_index;
  } result_t;

endpackage
`default_nettype wire

[rtl/fifo_multi_server_dispatcher.sv]
// Multi-server FIFO dispatcher, one input transaction per tick.
// The first result is registered in ServeSt, after FetchSt has read the job store.
// Per tick: each active server gets one job store read (FetchSt) and one result
//   (ServeSt), one output transaction at a time; no input is accepted until the last server is done.
// Reset: asynchronous, active low; pointers, counters and server timers clear,
//   active_servers returns to 2. The job store is not cleared.
`default_nettype none
module fifo_multi_server_dispatcher (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fmsd_pkg::ActW-1:0]      cfg_wdata_i,
  input  wire logic                           s_tvalid_i,
  output logic                                s_tready_o,
  // arrival, service_length, zero pad
  input  wire logic [fmsd_pkg::InDataW-1:0]   s_tdata_i,
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  // server_index, started, job_id, wait_ticks, busy_left, tick_now,
  // served_total, wait_total, waiting_count, arrival_dropped, zero pad
  output logic      [fmsd_pkg::OutDataW-1:0]  m_tdata_o,
  output logic                                m_tlast_o
);

  localparam int Depth = fmsd_pkg::QueueDepth;
  localparam int PtrW  = fmsd_pkg::PtrW;
  localparam int SrvW  = fmsd_pkg::SrvW;
  localparam int LenW  = fmsd_pkg::LenW;

  fmsd_pkg::state_e state_q, state_d;

  logic [fmsd_pkg::ActW-1:0]    active_q, active_d;
  logic [PtrW-1:0]              head_q, head_d, tail_q, tail_d;
  logic [LenW-1:0]              rem_q [fmsd_pkg::MaxServers];
  logic [LenW-1:0]              rem_d [fmsd_pkg::MaxServers];
  logic [fmsd_pkg::TickW-1:0]   tick_q, tick_d;
  logic [fmsd_pkg::IdW-1:0]     next_id_q, next_id_d;
  logic [fmsd_pkg::ServedW-1:0] served_q, served_d;
  logic [fmsd_pkg::SumW-1:0]    wsum_q, wsum_d;
  logic [SrvW-1:0]              srv_q, srv_d, last_q, last_d;
  logic                         dropped_q, dropped_d;
  logic                         out_valid_q;
  logic                         out_last_q, out_last_d;
  fmsd_pkg::result_t            res_q, res_d;

  logic                         accept, serve_fire, out_free;
  logic                         full, empty, start;
  logic                         wr_en;
  fmsd_pkg::job_t               wr_job, rd_job;
  logic [fmsd_pkg::JobW-1:0]    rd_data;
  logic [PtrW-1:0]              tail_next, head_next;
  logic [fmsd_pkg::ActW-1:0]    eff_cnt;
  logic [fmsd_pkg::TickW-1:0]   wait_val;
  logic [fmsd_pkg::SumW:0]      sum_ext;
  logic [PtrW-1:0]              level;
  logic [LenW-1:0]              rem_cur;

  fmsd_ram #(
    .Width (fmsd_pkg::JobW),
    .Depth (Depth)
  ) u_job_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (wr_job),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  assign rd_job    = fmsd_pkg::job_t'(rd_data);
  assign out_free  = !out_valid_q || m_tready_i;
  assign tail_next = (tail_q == PtrW'(Depth - 1)) ? '0 : tail_q + PtrW'(1);
  assign head_next = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + PtrW'(1);
  assign full      = (tail_next == head_q);
  assign empty     = (head_q == tail_q);
  assign rem_cur   = rem_q[srv_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      fmsd_pkg::IdleSt: begin
        if (s_tvalid_i) state_d = fmsd_pkg::FetchSt;
      end
      fmsd_pkg::FetchSt: begin
        state_d = fmsd_pkg::ServeSt;
      end
      fmsd_pkg::ServeSt: begin
        if (out_free) begin
          state_d = (srv_q == last_q) ? fmsd_pkg::IdleSt : fmsd_pkg::FetchSt;
        end
      end
      default: state_d = fmsd_pkg::IdleSt;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    serve_fire = 1'b0;
    case (state_q)
      fmsd_pkg::IdleSt:  s_tready_o = 1'b1;
      fmsd_pkg::ServeSt: serve_fire = out_free;
      default: begin
        s_tready_o = 1'b0;
        serve_fire = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid_i && s_tready_o;

  always_comb begin
    if (active_q == '0) begin
      eff_cnt = fmsd_pkg::ActW'(1);
    end else if (active_q > fmsd_pkg::ActW'(fmsd_pkg::MaxServers)) begin
      eff_cnt = fmsd_pkg::ActW'(fmsd_pkg::MaxServers);
    end else begin
      eff_cnt = active_q;
    end
  end

  always_comb begin
    active_d   = cfg_we_i ? cfg_wdata_i : active_q;
    head_d     = head_q;
    tail_d     = tail_q;
    rem_d      = rem_q;
    tick_d     = tick_q;
    next_id_d  = next_id_q;
    served_d   = served_q;
    wsum_d     = wsum_q;
    srv_d      = srv_q;
    last_d     = last_q;
    dropped_d  = dropped_q;
    res_d      = res_q;
    out_last_d = out_last_q;
    wr_en      = 1'b0;
    wr_job.id      = next_id_q;
    wr_job.arrived = tick_q + fmsd_pkg::TickW'(1);
    wr_job.length  = s_tdata_i[LenW:1];
    start      = 1'b0;
    wait_val   = '0;
    sum_ext    = '0;
    level      = '0;

    if (accept) begin
      tick_d    = tick_q + fmsd_pkg::TickW'(1);
      last_d    = SrvW'(eff_cnt - fmsd_pkg::ActW'(1));
      srv_d     = '0;
      dropped_d = s_tdata_i[0] && full;
      if (s_tdata_i[0] && !full) begin
        wr_en     = 1'b1;
        tail_d    = tail_next;
        next_id_d = next_id_q + fmsd_pkg::IdW'(1);
      end
    end

    if (serve_fire) begin
      start    = (rem_cur == '0) && !empty;
      wait_val = tick_q - rd_job.arrived;
      sum_ext  = {1'b0, wsum_q} + (fmsd_pkg::SumW + 1)'(wait_val);
      if (rem_cur != '0) begin
        rem_d[srv_q] = rem_cur - LenW'(1);
      end else if (start) begin
        head_d       = head_next;
        rem_d[srv_q] = (rd_job.length == '0) ? '0 : rd_job.length - LenW'(1);
        if (served_q != '1) served_d = served_q + fmsd_pkg::ServedW'(1);
        wsum_d = sum_ext[fmsd_pkg::SumW] ? '1 : sum_ext[fmsd_pkg::SumW-1:0];
      end
      level = tail_q - head_d;
      res_d.pad             = '0;
      res_d.arrival_dropped = dropped_q;
      res_d.waiting_count   = fmsd_pkg::LevelW'(level);
      res_d.wait_total      = wsum_d;
      res_d.served_total    = served_d;
      res_d.tick_now        = tick_q;
      res_d.busy_left       = rem_d[srv_q];
      res_d.wait_ticks      = start ? wait_val : '0;
      res_d.job_id          = start ? rd_job.id : '0;
      res_d.started         = start;
      res_d.server_index    = fmsd_pkg::IdxW'(srv_q);
      out_last_d            = (srv_q == last_q);
      srv_d                 = srv_q + SrvW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmsd_pkg::IdleSt;
      active_q    <= fmsd_pkg::ActiveReset;
      head_q      <= '0;
      tail_q      <= '0;
      for (int i = 0; i < fmsd_pkg::MaxServers; i++) rem_q[i] <= '0;
      tick_q      <= '0;
      next_id_q   <= '0;
      served_q    <= '0;
      wsum_q      <= '0;
      srv_q       <= '0;
      last_q      <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rem_q       <= rem_d;
      tick_q      <= tick_d;
      next_id_q   <= next_id_d;
      served_q    <= served_d;
      wsum_q      <= wsum_d;
      srv_q       <= srv_d;
      last_q      <= last_d;
      dropped_q   <= dropped_d;
      out_last_q  <= out_last_d;
      if (serve_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = res_q;
  assign m_tlast_o  = out_last_q;

  a_head_moves_on_serve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |-> ($past(state_q) == fmsd_pkg::ServeSt))
    else $error("head pointer moved outside a server visit");

  a_served_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (served_q >= $past(served_q)))
    else $error("served count decreased");

  a_srv_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fmsd_pkg::IdleSt) |-> (srv_q <= last_q))
    else $error("server index beyond last active server");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (serve_fire && out_valid_q) |-> m_tready_i)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

[rtl/fmsd_ram.sv]
`default_nettype none
module fmsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[sim/fifo_multi_server_dispatcher_test.sv]
`timescale 1ns / 100ps
module fifo_multi_server_dispatcher_test;
  import fmsd_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int NumRows    = 24;
  localparam int StallLen   = 2000;
  localparam int PhaseTicks = 45;

  typedef enum logic {
    RowTick,
    RowCfg
  } row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [ActW-1:0] cfg;
    logic            arr;
    logic [LenW-1:0] len;
    logic            known;
    logic            st;
    logic [IdW-1:0]  id;
    logic [LenW-1:0] busy;
    logic [TickW-1:0] tick;
    logic [LevelW-1:0] lvl;
    logic            drop;
  } stim_row_t;

  typedef struct {
    result_t res;
    logic    last;
  } server_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [ActW-1:0]       cfg_wdata_i;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [InDataW-1:0]    s_tdata_i;
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [OutDataW-1:0]   m_tdata_o;
  logic                  m_tlast_o;

  // dispatcher shadow state
  job_t                  job_mem [QueueDepth];
  int unsigned           rd_ptr;
  int unsigned           wr_ptr;
  logic [LenW-1:0]       srv_left [MaxServers];
  logic [TickW-1:0]      tick_ctr;
  logic [IdW-1:0]        id_ctr;
  logic [ServedW-1:0]    served_ctr;
  logic [SumW-1:0]       wait_acc;
  logic [ActW-1:0]       active_cfg;

  server_report_t        pending_results [$];
  stim_row_t             directed_rows [NumRows];
  logic [ActW-1:0]       phase_active [6] = '{3'd4, 3'd3, 3'd1, 3'd7, 3'd2, 3'd0};

  int unsigned           mismatches = 0;
  int unsigned           cycle_count = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  logic                  stall_request = 1'b0;
  logic                  stall_served = 1'b0;
  int unsigned           stall_left = 0;
  result_t               got_res;
  server_report_t        want_rep;

  fifo_multi_server_dispatcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
    if (got !== want) begin
      $display("%0t mismatch %s: got %0h want %0h", $realtime, name, got, want);
      mismatches++;
    end
  endtask

  // one tick of the dispatcher; queues one report per visited server
  task automatic dispatch_tick(input logic arr, input logic [LenW-1:0] len,
                               output result_t first);
    int unsigned    nsrv;
    logic           drop;
    job_t           j;
    logic [31:0]    w;
    server_report_t o;
    nsrv = (active_cfg == 0) ? 1 : ((active_cfg > MaxServers) ? MaxServers : active_cfg);
    tick_ctr = tick_ctr + TickW'(1);
    drop = 1'b0;
    if (arr) begin
      if ((wr_ptr + 1) % QueueDepth == rd_ptr) begin
        drop = 1'b1;
      end else begin
        job_mem[wr_ptr] = '{id: id_ctr, arrived: tick_ctr, length: len};
        id_ctr = id_ctr + IdW'(1);
        wr_ptr = (wr_ptr + 1) % QueueDepth;
      end
    end
    for (int s = 0; s < nsrv; s++) begin
      o.res = '0;
      if (srv_left[s] != 0) begin
        srv_left[s] = srv_left[s] - LenW'(1);
      end else if (rd_ptr != wr_ptr) begin
        j = job_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % QueueDepth;
        w = tick_ctr - j.arrived;
        o.res.started = 1'b1;
        o.res.job_id = j.id;
        o.res.wait_ticks = w;
        srv_left[s] = (j.length == 0) ? 8'd0 : j.length - LenW'(1);
        if (served_ctr != '1) served_ctr = served_ctr + ServedW'(1);
        if (wait_acc > ({SumW{1'b1}} - {16'b0, w})) wait_acc = '1;
        else wait_acc = wait_acc + {16'b0, w};
      end
      o.res.server_index = s[IdxW-1:0];
      o.res.busy_left = srv_left[s];
      o.res.tick_now = tick_ctr;
      o.res.served_total = served_ctr;
      o.res.wait_total = wait_acc;
      o.res.waiting_count = LevelW'((wr_ptr + QueueDepth - rd_ptr) % QueueDepth);
      o.res.arrival_dropped = drop;
      o.last = (s + 1 == nsrv);
      if (s == 0) first = o.res;
      pending_results.push_back(o);
    end
  endtask

  // entered and left at a falling edge
  task automatic send_tick(input logic arr, input logic [LenW-1:0] len,
                           output result_t first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i = {7'b0, len, arr};
    do @(posedge clk_i); while (!s_tready_o);
    dispatch_tick(arr, len, first);
    @(negedge clk_i);
  endtask

  task automatic write_active(input logic [ActW-1:0] v);
    s_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    active_cfg = v;
  endtask

  always begin
    @(negedge clk_i);
    if (stall_request && !stall_served) begin
      stall_left = StallLen;
      stall_served = 1'b1;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready_i = 1'b0;
    end else begin
      m_tready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        report_field("result with none expected", 1, 0);
      end else begin
        want_rep = pending_results.pop_front();
        got_res = result_t'(m_tdata_o);
        report_field("server_index", got_res.server_index, want_rep.res.server_index);
        report_field("started", got_res.started, want_rep.res.started);
        report_field("job_id", got_res.job_id, want_rep.res.job_id);
        report_field("wait_ticks", got_res.wait_ticks, want_rep.res.wait_ticks);
        report_field("busy_left", got_res.busy_left, want_rep.res.busy_left);
        report_field("tick_now", got_res.tick_now, want_rep.res.tick_now);
        report_field("served_total", got_res.served_total, want_rep.res.served_total);
        report_field("wait_total", got_res.wait_total, want_rep.res.wait_total);
        report_field("waiting_count", got_res.waiting_count, want_rep.res.waiting_count);
        report_field("arrival_dropped", got_res.arrival_dropped,
                     want_rep.res.arrival_dropped);
        report_field("tlast", m_tlast_o, want_rep.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    result_t         first;
    int unsigned     arr_pct;
    int unsigned     pick;
    logic [LenW-1:0] len;

    directed_rows = '{
      '{RowTick, 3'd0, 1'b0, 8'd0,   1'b1, 1'b0, 16'd0, 8'd0,   32'd1,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd1,   1'b1, 1'b1, 16'd0, 8'd0,   32'd2,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd255, 1'b1, 1'b1, 16'd1, 8'd254, 32'd3,  7'd0, 1'b0},
      // zero length counts as one
      '{RowTick, 3'd0, 1'b1, 8'd0,   1'b1, 1'b0, 16'd0, 8'd253, 32'd4,  7'd1, 1'b0},
      // length ignored without arrival
      '{RowTick, 3'd0, 1'b0, 8'd255, 1'b1, 1'b0, 16'd0, 8'd252, 32'd5,  7'd0, 1'b0},
      '{RowCfg,  3'd1, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd128, 1'b1, 1'b0, 16'd0, 8'd251, 32'd6,  7'd1, 1'b0},
      '{RowCfg,  3'd4, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd3,   1'b1, 1'b0, 16'd0, 8'd250, 32'd7,  7'd2, 1'b0},
      // zero servers acts as one
      '{RowCfg,  3'd0, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd2,   1'b1, 1'b0, 16'd0, 8'd249, 32'd8,  7'd1, 1'b0},
      // above max acts as max
      '{RowCfg,  3'd7, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'h55,  1'b1, 1'b0, 16'd0, 8'd248, 32'd9,  7'd2, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'hAA,  1'b1, 1'b0, 16'd0, 8'd247, 32'd10, 7'd2, 1'b0},
      '{RowCfg,  3'd5, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowCfg,  3'd6, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'h7F,  1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'h80,  1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowCfg,  3'd3, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd1,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowCfg,  3'd2, 1'b0, 8'd0,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0},
      '{RowTick, 3'd0, 1'b1, 8'd4,   1'b0, 1'b0, 16'd0, 8'd0,   32'd0,  7'd0, 1'b0}
    };

    rd_ptr = 0;
    wr_ptr = 0;
    for (int s = 0; s < MaxServers; s++) srv_left[s] = '0;
    tick_ctr = '0;
    id_ctr = '0;
    served_ctr = '0;
    wait_acc = '0;
    active_cfg = ActiveReset;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (directed_rows[i].kind == RowCfg) begin
        write_active(directed_rows[i].cfg);
      end else begin
        send_tick(directed_rows[i].arr, directed_rows[i].len, first);
        if (directed_rows[i].known) begin
          report_field("row started", first.started, directed_rows[i].st);
          report_field("row job_id", first.job_id, directed_rows[i].id);
          report_field("row busy_left", first.busy_left, directed_rows[i].busy);
          report_field("row tick_now", first.tick_now, directed_rows[i].tick);
          report_field("row waiting_count", first.waiting_count, directed_rows[i].lvl);
          report_field("row arrival_dropped", first.arrival_dropped, directed_rows[i].drop);
        end
      end
    end

    // one busy server, output held off: queue overflows and input backs up
    write_active(3'd1);
    stall_request = 1'b1;
    send_tick(1'b1, 8'd200, first);
    for (int k = 0; k < 145; k++) send_tick(1'b1, 8'd1, first);

    for (int p = 0; p < 6; p++) begin
      write_active(phase_active[p]);
      send_idle_pct = (p < 2) ? 29 : ((p < 4) ? 77 : 0);
      recv_idle_pct = (p < 2) ? 77 : ((p < 4) ? 29 : 0);
      arr_pct = $urandom_range(95, 25);
      for (int k = 0; k < PhaseTicks; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) len = LenW'($urandom_range(4, 1));
        else if (pick < 90) len = LenW'($urandom_range(20, 5));
        else if (pick < 94) len = '0;
        else len = LenW'($urandom_range(255, 0));
        send_tick($urandom_range(99) < arr_pct, len, first);
      end
    end

    s_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
